>>> rtl/spm_pkg.sv
// package for the sparse polynomial multiplier
// shared constants, types and controller/datapath command structs
package spm_pkg;
    localparam int MaxTerms   = 8;
    localparam int TableDepth = MaxTerms * MaxTerms;
    localparam int TermIdxW   = $clog2(MaxTerms);
    localparam int TermCntW   = $clog2(MaxTerms + 1);
    localparam int TabIdxW    = $clog2(TableDepth);
    localparam int TabCntW    = $clog2(TableDepth + 1);
    localparam int DegW       = 8;
    localparam int OutDegW    = 9;
    localparam int CoefW      = 32;
    localparam int AccW       = 64;

    localparam int DegSpan    = 1 << OutDegW;

    typedef struct packed {
        logic               load_first;
        logic               load_second;
        logic               clear_counts;
        logic               wipe_issue;
        logic               mul_issue;
        logic [TermIdxW-1:0] idx_i;
        logic [TermIdxW-1:0] idx_j;
        logic               acc_issue;
        logic               scan_issue;
        logic [OutDegW-1:0] scan_deg;
    } t_cmd;

    typedef struct packed {
        logic [TermCntW-1:0] first_count;
        logic [TermCntW-1:0] second_count;
        logic                emitted_any;
        logic                pipe_busy;
    } t_status;
endpackage

>>> rtl/spm_datapath.sv
// datapath: operand stores, multiplier pipeline, degree-indexed accumulator memory
// depends on spm_pkg
module spm_datapath import spm_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    input  logic [DegW-1:0]          i_term_degree,
    input  logic signed [CoefW-1:0]  i_term_coefficient,
    output t_status                  o_status,
    output logic                     o_valid,
    output logic [OutDegW-1:0]       o_out_degree,
    output logic signed [CoefW-1:0]  o_out_coefficient
);
    logic [DegW-1:0]         r_fdeg [MaxTerms];
    logic signed [CoefW-1:0] r_fcoef [MaxTerms];
    logic [DegW-1:0]         r_sdeg [MaxTerms];
    logic signed [CoefW-1:0] r_scoef [MaxTerms];
    logic [TermCntW-1:0]     r_fcnt, r_scnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fcnt <= '0;
            r_scnt <= '0;
        end else if (i_cmd.clear_counts) begin
            r_fcnt <= '0;
            r_scnt <= '0;
        end else begin
            if (i_cmd.load_first && r_fcnt < TermCntW'(MaxTerms)) begin
                r_fdeg[r_fcnt[TermIdxW-1:0]]  <= i_term_degree;
                r_fcoef[r_fcnt[TermIdxW-1:0]] <= i_term_coefficient;
                r_fcnt <= r_fcnt + 1'b1;
            end
            if (i_cmd.load_second && r_scnt < TermCntW'(MaxTerms)) begin
                r_sdeg[r_scnt[TermIdxW-1:0]]  <= i_term_degree;
                r_scoef[r_scnt[TermIdxW-1:0]] <= i_term_coefficient;
                r_scnt <= r_scnt + 1'b1;
            end
        end
    end

    // stage 1: operand fetch and product
    logic                    r_m_v;
    logic [OutDegW-1:0]      r_m_deg;
    logic signed [AccW-1:0]  r_m_prod;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_m_v <= 1'b0;
        else          r_m_v <= i_cmd.mul_issue;
        r_m_deg  <= {1'b0, r_fdeg[i_cmd.idx_i]} + {1'b0, r_sdeg[i_cmd.idx_j]};
        r_m_prod <= AccW'(r_fcoef[i_cmd.idx_i]) * AccW'(r_scoef[i_cmd.idx_j]);
    end

    // stage 2: floor shift, memory read request
    logic                   r_s_v;
    logic [OutDegW-1:0]     r_s_deg;
    logic signed [AccW-1:0] r_s_val;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s_v <= 1'b0;
        else          r_s_v <= r_m_v;
        r_s_deg <= r_m_deg;
        r_s_val <= r_m_prod >>> 16;
    end

    // accumulator memory, kept all zero between jobs
    logic [AccW-1:0]    r_mem [DegSpan];
    logic [AccW-1:0]    r_rd;
    logic [OutDegW-1:0] rd_addr;
    logic               r_w_v;
    logic [OutDegW-1:0] r_w_deg;
    logic signed [AccW-1:0] r_w_sum;
    assign rd_addr = i_cmd.scan_issue ? i_cmd.scan_deg : r_m_deg;

    // take the sum written at the same edge
    always_ff @(posedge i_clk) begin
        if (r_w_v && r_w_deg == rd_addr) r_rd <= r_w_sum;
        else                             r_rd <= r_mem[rd_addr];
    end

    // stage 3: add; forward from previous write on same degree
    logic signed [AccW-1:0] base;
    always_comb begin
        if (r_w_v && r_w_deg == r_s_deg) base = r_w_sum;
        else                             base = r_rd;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_w_v <= 1'b0;
        else          r_w_v <= r_s_v;
        r_w_deg <= r_s_deg;
        r_w_sum <= base + r_s_val;
    end

    // scanned and wiped entries are cleared
    always_ff @(posedge i_clk) begin
        if (r_w_v) r_mem[r_w_deg] <= r_w_sum;
        else if (i_cmd.scan_issue || i_cmd.wipe_issue) r_mem[i_cmd.scan_deg] <= '0;
    end

    // scan: read issued, data in the next cycle
    logic               r_sc_v;
    logic [OutDegW-1:0] r_sc_deg;
    logic               r_any;
    logic signed [AccW-1:0] sv;
    logic               nz;
    logic signed [CoefW-1:0] sat;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_sc_v <= 1'b0;
        else          r_sc_v <= i_cmd.scan_issue;
        r_sc_deg <= i_cmd.scan_deg;
    end
    always_comb begin
        sv = r_rd;
        if (sv > AccW'(64'sd2147483647))       sat = 32'sh7fffffff;
        else if (sv < -AccW'(64'sd2147483648)) sat = 32'sh80000000;
        else                                   sat = sv[CoefW-1:0];
        nz = r_sc_v && (sat != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear_counts) r_any <= 1'b0;
        else if (nz) r_any <= 1'b1;
    end

    assign o_valid           = nz;
    assign o_out_degree      = r_sc_deg;
    assign o_out_coefficient = sat;

    assign o_status.first_count  = r_fcnt;
    assign o_status.second_count = r_scnt;
    assign o_status.emitted_any  = r_any;
    assign o_status.pipe_busy    = r_m_v | r_s_v | r_w_v;
endmodule

>>> rtl/spm_ctrl.sv
// controller: memory clear, load, multiply sweep, degree scan, output holding
// depends on spm_pkg
module spm_ctrl import spm_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic                    i_which_operand,
    input  logic                    i_last_term,
    input  t_status                 i_status,
    input  logic                    i_dp_valid,
    input  logic [OutDegW-1:0]      i_dp_degree,
    input  logic signed [CoefW-1:0] i_dp_coef,
    output t_cmd                    o_cmd,
    output logic                    o_busy,
    output logic                    o_valid,
    output logic [OutDegW-1:0]      o_out_degree,
    output logic signed [CoefW-1:0] o_out_coefficient,
    output logic                    o_out_last
);
    localparam logic [2:0] StIdle  = 3'd0;
    localparam logic [2:0] StClear = 3'd1;
    localparam logic [2:0] StMul   = 3'd2;
    localparam logic [2:0] StDrain = 3'd3;
    localparam logic [2:0] StScan  = 3'd4;
    localparam logic [2:0] StFlush = 3'd5;
    localparam logic [2:0] StDone  = 3'd6;
    localparam logic [2:0] StInit  = 3'd7;

    logic [2:0]          r_st, n_st;
    logic [TermIdxW-1:0] r_i, n_i, r_j, n_j;
    logic [OutDegW:0]    r_d, n_d;
    logic [1:0]          r_fl, n_fl;
    logic                r_hv;
    logic [OutDegW-1:0]  r_hdeg;
    logic signed [CoefW-1:0] r_hcoef;
    logic                accept;
    logic                fempty, sempty;
    logic                flush_out;

    assign accept = i_start && !o_busy;
    assign o_busy = (r_st != StIdle);
    assign fempty = (i_status.first_count == '0);
    assign sempty = (i_status.second_count == '0);

    always_comb begin
        n_st = r_st; n_i = r_i; n_j = r_j; n_d = r_d; n_fl = r_fl;
        o_cmd = '0;
        o_cmd.idx_i = r_i;
        o_cmd.idx_j = r_j;
        o_cmd.scan_deg = r_d[OutDegW-1:0];
        case (r_st)
            StInit: begin
                o_cmd.wipe_issue = 1'b1;
                n_d = r_d + 1'b1;
                if (r_d == (OutDegW+1)'(DegSpan - 1)) n_st = StIdle;
            end
            StIdle: begin
                if (accept) begin
                    o_cmd.load_first  = !i_which_operand;
                    o_cmd.load_second = i_which_operand;
                    if (i_which_operand && i_last_term) n_st = StClear;
                end
            end
            StClear: begin
                n_i = '0; n_j = '0; n_d = '0;
                n_st = (fempty || sempty) ? StDrain : StMul;
            end
            StMul: begin
                o_cmd.mul_issue = 1'b1;
                if ({1'b0, r_j} == i_status.second_count - 1'b1) begin
                    n_j = '0;
                    if ({1'b0, r_i} == i_status.first_count - 1'b1) n_st = StDrain;
                    else n_i = r_i + 1'b1;
                end else begin
                    n_j = r_j + 1'b1;
                end
            end
            StDrain: begin
                if (!i_status.pipe_busy && !o_cmd.mul_issue) n_st = StScan;
            end
            StScan: begin
                o_cmd.scan_issue = 1'b1;
                n_d = r_d + 1'b1;
                if (r_d == (OutDegW+1)'(DegSpan - 1)) begin
                    n_st = StFlush;
                    n_fl = 2'd2;
                end
            end
            StFlush: begin
                n_fl = r_fl - 1'b1;
                if (r_fl == 2'd1) n_st = StDone;
            end
            StDone: begin
                o_cmd.clear_counts = 1'b1;
                n_st = StIdle;
            end
            default: n_st = StIdle;
        endcase
    end

    // hold one result so the last flag can be set on the final one
    assign flush_out = (r_st == StFlush) && (r_fl == 2'd1);
    always_comb begin
        o_valid = 1'b0;
        o_out_last = 1'b0;
        o_out_degree = r_hdeg;
        o_out_coefficient = r_hcoef;
        if (r_hv && (i_dp_valid || flush_out)) begin
            o_valid = 1'b1;
            o_out_last = flush_out && !i_dp_valid;
        end else if (flush_out && !i_status.emitted_any) begin
            o_valid = 1'b1;
            o_out_last = 1'b1;
            o_out_degree = '0;
            o_out_coefficient = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= StInit;
            r_i <= '0; r_j <= '0; r_d <= '0; r_fl <= '0;
            r_hv <= 1'b0;
        end else begin
            r_st <= n_st; r_i <= n_i; r_j <= n_j; r_d <= n_d; r_fl <= n_fl;
            if (i_dp_valid) r_hv <= 1'b1;
            else if (flush_out) r_hv <= 1'b0;
        end
        if (i_dp_valid) begin
            r_hdeg  <= i_dp_degree;
            r_hcoef <= i_dp_coef;
        end
    end
endmodule

>>> rtl/sparse_polynomial_multiply_top.sv
// top level of the sparse polynomial multiplier
// depends on spm_pkg, spm_ctrl, spm_datapath
// After reset busy stays high while the degree-indexed accumulator memory is
// cleared. Terms then load one per cycle while busy is low. A second-operand
// term with last_term set starts the job: busy stays high through the
// multiply-accumulate sweep (skipped when an operand is empty), the scan
// that reads and clears the accumulator memory, and a final wrap-up.
// Results come out in increasing degree, one strobe cycle each, and cannot
// be stalled; the final one carries o_out_last.
module sparse_polynomial_multiply_top import spm_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic                    i_which_operand,
    input  logic [DegW-1:0]         i_term_degree,
    input  logic signed [CoefW-1:0] i_term_coefficient,
    input  logic                    i_last_term,
    output logic                    o_valid,
    output logic [OutDegW-1:0]      o_out_degree,
    output logic signed [CoefW-1:0] o_out_coefficient,
    output logic                    o_out_last
);
    t_cmd    cmd;
    t_status status;
    logic    dp_valid;
    logic [OutDegW-1:0] dp_deg;
    logic signed [CoefW-1:0] dp_coef;

    spm_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_start(start),
        .i_which_operand, .i_last_term,
        .i_status(status), .i_dp_valid(dp_valid),
        .i_dp_degree(dp_deg), .i_dp_coef(dp_coef),
        .o_cmd(cmd), .o_busy(busy), .o_valid,
        .o_out_degree, .o_out_coefficient, .o_out_last
    );

    spm_datapath u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd),
        .i_term_degree, .i_term_coefficient,
        .o_status(status), .o_valid(dp_valid),
        .o_out_degree(dp_deg), .o_out_coefficient(dp_coef)
    );
endmodule

>>> rtl/spm_checker.sv
// port-level checks for the sparse polynomial multiplier
// bound to sparse_polynomial_multiply_top
module spm_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic i_which_operand,
    input logic i_last_term,
    input logic o_valid,
    input logic o_out_last
);
    a_last_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_last |-> o_valid) else $error("last without valid");
    a_start_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_which_operand && i_last_term) |=> busy)
        else $error("job did not start");
    a_no_out_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy |-> !o_valid) else $error("result while idle");
    a_done_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out_last) |=> ##1 !busy) else $error("busy after last");
endmodule

bind sparse_polynomial_multiply_top spm_checker u_spm_checker (
    .i_clk, .i_rst_n, .start, .busy, .i_which_operand, .i_last_term,
    .o_valid, .o_out_last
);

>>> dv/sparse_polynomial_multiply_top_tb.sv
// testbench for sparse_polynomial_multiply_top: loads random sparse operands,
// predicts the product terms in-bench and checks every output transaction
// depends on spm_pkg and the rtl under rtl/
`timescale 1ns / 1ps

module sparse_polynomial_multiply_top_tb;
    import spm_pkg::*;

    typedef struct {
        logic               which;
        logic [DegW-1:0]    deg;
        logic signed [CoefW-1:0] coef;
        logic               last;
    } t_term_item;

    typedef struct {
        logic [OutDegW-1:0]      deg;
        logic signed [CoefW-1:0] coef;
        logic                    last;
    } t_prod_term;

    localparam int WatchdogLimit = 20000;
    localparam int DrainCycles   = 600;

    logic                    clk;
    logic                    rst_n;
    logic                    start;
    logic                    busy;
    logic                    which_operand;
    logic [DegW-1:0]         term_degree;
    logic signed [CoefW-1:0] term_coefficient;
    logic                    last_term;
    logic                    o_valid;
    logic [OutDegW-1:0]      o_out_degree;
    logic signed [CoefW-1:0] o_out_coefficient;
    logic                    o_out_last;

    t_term_item pending_terms[$];
    t_prod_term expected_terms[$];
    int         errors = 0;
    int         idle_cycles = 0;
    bit         stim_done = 0;
    bit         hold_send = 0;
    bit         no_gaps = 0;

    // predictor state
    logic [DegW-1:0]         a_deg[MaxTerms];
    logic signed [CoefW-1:0] a_coef[MaxTerms];
    logic [DegW-1:0]         b_deg[MaxTerms];
    logic signed [CoefW-1:0] b_coef[MaxTerms];
    int                      a_cnt = 0;
    int                      b_cnt = 0;

    sparse_polynomial_multiply_top dut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .start              (start),
        .busy               (busy),
        .i_which_operand    (which_operand),
        .i_term_degree      (term_degree),
        .i_term_coefficient (term_coefficient),
        .i_last_term        (last_term),
        .o_valid            (o_valid),
        .o_out_degree       (o_out_degree),
        .o_out_coefficient  (o_out_coefficient),
        .o_out_last         (o_out_last)
    );

    always begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    task automatic predict_product(input t_term_item t);
        logic signed [2*CoefW-1:0] sums[DegSpan];
        bit                        used[DegSpan];
        logic signed [2*CoefW-1:0] p;
        logic signed [2*CoefW-1:0] s;
        t_prod_term                r;
        int                        n;
        int                        d;
        n = 0;
        if (!t.which) begin
            if (a_cnt < MaxTerms) begin
                a_deg[a_cnt] = t.deg;
                a_coef[a_cnt] = t.coef;
                a_cnt++;
            end
            return;
        end
        if (b_cnt < MaxTerms) begin
            b_deg[b_cnt] = t.deg;
            b_coef[b_cnt] = t.coef;
            b_cnt++;
        end
        if (!t.last) return;
        for (d = 0; d < DegSpan; d++) begin
            used[d] = 0;
            sums[d] = '0;
        end
        for (int i = 0; i < a_cnt; i++) begin
            for (int j = 0; j < b_cnt; j++) begin
                d = int'(a_deg[i]) + int'(b_deg[j]);
                p = (64'(signed'(a_coef[i])) * 64'(signed'(b_coef[j]))) >>> 16;
                used[d] = 1;
                sums[d] += p;
            end
        end
        for (d = 0; d < DegSpan; d++) begin
            if (!used[d]) continue;
            s = sums[d];
            if (s > 64'sd2147483647) s = 64'sd2147483647;
            if (s < -64'sd2147483648) s = -64'sd2147483648;
            if (s == 0) continue;
            r.deg = OutDegW'(d);
            r.coef = s[CoefW-1:0];
            r.last = 1'b0;
            expected_terms.push_back(r);
            n++;
        end
        if (n == 0) begin
            r.deg = '0;
            r.coef = '0;
            r.last = 1'b1;
            expected_terms.push_back(r);
        end else begin
            expected_terms[expected_terms.size() - 1].last = 1'b1;
        end
        a_cnt = 0;
        b_cnt = 0;
    endtask

    function automatic logic signed [CoefW-1:0] rand_coef();
        case ($urandom_range(0, 5))
            0: return 32'sh7FFFFFFF;
            1: return 32'sh80000000;
            2: return 32'(signed'($urandom_range(0, 8))) <<< 16;
            3: return -(32'(signed'($urandom_range(1, 8))) <<< 16);
            default: return $urandom;
        endcase
    endfunction

    task automatic add_term(input logic w, input logic [DegW-1:0] d,
                            input logic signed [CoefW-1:0] c, input logic l);
        t_term_item t;
        t.which = w;
        t.deg = d;
        t.coef = c;
        t.last = l;
        pending_terms.push_back(t);
    endtask

    // one job: first operand then second, with occasional overflow and stray flags
    task automatic add_job(input int n1, input int n2, input int deg_hi);
        for (int i = 0; i < n1; i++)
            add_term(1'b0, DegW'($urandom_range(0, deg_hi)), rand_coef(),
                     1'($urandom_range(0, 9) == 0));
        for (int i = 0; i < n2; i++)
            add_term(1'b1, DegW'($urandom_range(0, deg_hi)), rand_coef(), i == n2 - 1);
    endtask

    // driver
    always @(posedge clk) begin
        if (!rst_n) begin
            start <= 1'b0;
        end else if (!start || !busy) begin
            if (pending_terms.size() > 0 && !hold_send
                    && (no_gaps || $urandom_range(0, 99) >= 29)) begin
                t_term_item t;
                t = pending_terms.pop_front();
                which_operand <= t.which;
                term_degree <= t.deg;
                term_coefficient <= t.coef;
                last_term <= t.last;
                start <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor and prediction
    always @(posedge clk) begin
        if (rst_n) begin
            if (start && !busy) begin
                t_term_item t;
                t.which = which_operand;
                t.deg = term_degree;
                t.coef = term_coefficient;
                t.last = last_term;
                predict_product(t);
            end
            if (o_valid) begin
                if (expected_terms.size() == 0) begin
                    $display("%0t unexpected transaction deg %0d coef %0d last %0b",
                             $time, o_out_degree, o_out_coefficient, o_out_last);
                    errors++;
                end else begin
                    t_prod_term e;
                    e = expected_terms.pop_front();
                    if (e.deg !== o_out_degree || e.coef !== o_out_coefficient
                            || e.last !== o_out_last) begin
                        $display("%0t mismatch expected deg %0d coef %0d last %0b, actual deg %0d coef %0d last %0b",
                                 $time, e.deg, e.coef, e.last,
                                 o_out_degree, o_out_coefficient, o_out_last);
                        errors++;
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge clk) begin
        if ((start && !busy) || o_valid || !rst_n) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchdogLimit) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        start = 1'b0;
        which_operand = 1'b0;
        term_degree = '0;
        term_coefficient = '0;
        last_term = 1'b0;
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, empty operands, overflow, zero cancel, last on first
        add_term(1'b0, 8'd255, 32'sh7FFFFFFF, 1'b1);
        add_term(1'b1, 8'd255, 32'sh7FFFFFFF, 1'b1);
        add_term(1'b0, 8'd0, 32'sh80000000, 1'b0);
        add_term(1'b1, 8'd0, 32'sh80000000, 1'b1);
        add_term(1'b1, 8'd3, 32'sh00010000, 1'b1);
        add_term(1'b0, 8'd1, 32'sh00010000, 1'b0);
        add_term(1'b0, 8'd1, -32'sh00010000, 1'b0);
        add_term(1'b1, 8'd2, 32'sh00020000, 1'b1);
        add_term(1'b0, 8'd0, 32'sh00000001, 1'b0);
        add_term(1'b1, 8'd0, 32'sh00000001, 1'b1);
        add_term(1'b0, 8'd0, -32'sh00000001, 1'b0);
        add_term(1'b1, 8'd0, 32'sh00000001, 1'b1);
        for (int i = 0; i < 10; i++)
            add_term(1'b0, DegW'(i * 25), rand_coef(), 1'b0);
        add_term(1'b1, 8'd170, 32'sh55555555, 1'b1);

        while (pending_terms.size() < 420) begin
            case ($urandom_range(0, 9))
                0: add_job($urandom_range(0, 10), $urandom_range(1, 10), 255);
                1: add_term(1'($urandom), DegW'($urandom), rand_coef(), 1'($urandom));
                default: add_job($urandom_range(1, 4), $urandom_range(1, 4),
                                 $urandom_range(0, 1) ? 7 : 255);
            endcase
        end

        wait (pending_terms.size() < 300);
        hold_send = 1;
        repeat (2) @(posedge clk);
        wait (expected_terms.size() == 0 && busy == 1'b0);
        repeat (5) @(posedge clk);
        hold_send = 0;
        no_gaps = 1;
        wait (pending_terms.size() < 200);
        no_gaps = 0;

        wait (pending_terms.size() == 0);
        @(posedge clk);
        wait (start == 1'b0);
        @(posedge clk);
        wait (expected_terms.size() == 0 && busy == 1'b0);
        repeat (DrainCycles) @(posedge clk);
        if (errors == 0 && expected_terms.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
